// ===== rtl/knn_pkg.sv =====
// shared constants and types for the knn digit classifier
package knn_pkg;
  localparam int MaxEntries = 1024;
  localparam int ImagePixels = 784;
  localparam int MaxNeighbours = 16;
  localparam int NumClasses = 10;
  localparam int EntryW = 10;
  localparam int PosW = 10;
  localparam int CountW = 11;
  localparam int KW = 5;
  localparam int DistW = 26;
  localparam int SlotW = 4;
  localparam int VoteW = 5;
  localparam int PixAddrW = 20;

  localparam logic [0:0] CmdLoad = 1'b0;
  localparam logic [0:0] CmdQuery = 1'b1;
  localparam logic [0:0] RegK = 1'b0;
  localparam logic [0:0] RegCount = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIST, ST_INSERT, ST_VOTE, ST_PICK, ST_OUT
  } state_t;

  typedef struct packed {
    logic [EntryW-1:0] entry;
    logic [PosW-1:0]  pos;
    logic             acc_clr;
    logic             acc_en;
  } dist_ctrl_t;
endpackage

// ===== rtl/knn_digit_classifier_top.sv =====
// top level of the knn digit classifier
// a training load or a non-final query pixel is taken while idle. the final query pixel starts a
// classification: each of the entry_count entries in turn has its pixel pairs read, one pair per
// cycle, from the training and query memories into a squared difference accumulator; each entry
// that beats the current k-th neighbour, or any entry while fewer than k are kept, is then
// inserted into the sorted neighbour list one slot per cycle. then the votes are counted, the
// winner is found and moved into the result register. no input word is taken meanwhile; a word
// waiting there does not hold off input, only the end of the next classification.
module knn_digit_classifier_top import knn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [9:0]  in_entry,
  input  logic [9:0]  in_pixel_pos,
  input  logic [7:0]  in_pixel,
  input  logic [3:0]  in_label,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_digit,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  state_t state_r, state_nxt;
  logic [KW-1:0] k_r;
  logic [CountW-1:0] count_r;
  logic [EntryW:0] e_r, e_nxt;
  logic [PosW-1:0] p_r, p_nxt;
  logic [1:0] tail_r, tail_nxt;
  logic [DistW-1:0] nd_r [MaxNeighbours];
  logic [3:0] nl_r [MaxNeighbours];
  logic [VoteW-1:0] vc_r [NumClasses];
  logic [KW-1:0] kept_r, kept_nxt, ks, slot_r, slot_nxt;
  logic [3:0] best_r, best_nxt, cls_r, cls_nxt;
  logic [3:0] digit_r;
  logic out_valid_r;
  logic [DistW-1:0] dist_sum;
  logic [3:0] lbl;
  logic [DistW-1:0] cur_d_r;
  logic [3:0] cur_l_r;
  dist_ctrl_t ctrl;
  logic acc;
  logic ld_we, q_we, fire;
  logic [CountW-1:0] cnt_sat;
  logic [SlotW-1:0] last_slot;
  logic skip;

  assign acc = in_valid && in_ready;
  assign ld_we = acc && in_cmd == CmdLoad && in_pixel_pos < PosW'(ImagePixels);
  assign q_we = acc && in_cmd == CmdQuery && in_pixel_pos < PosW'(ImagePixels);
  assign fire = q_we && in_pixel_pos == PosW'(ImagePixels - 1);
  assign ks = k_r > KW'(MaxNeighbours) ? KW'(MaxNeighbours) : k_r;
  assign cnt_sat = count_r > CountW'(MaxEntries) ? CountW'(MaxEntries) : count_r;
  assign last_slot = SlotW'(ks - 1'b1);
  // a full list keeps its entries unless the new (distance, label) is below the last one's
  assign skip = kept_r == ks &&
                {dist_sum, lbl} >= {nd_r[last_slot], nl_r[last_slot]};

  knn_store u_store (
    .clk, .ld_we, .ld_entry(in_entry), .ld_pos(in_pixel_pos), .ld_pixel(in_pixel),
    .ld_label(in_label), .q_we, .q_pos(in_pixel_pos), .q_pixel(in_pixel),
    .ctrl, .dist_sum, .lbl
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= KW'(3);
      count_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegK) k_r <= cfg_data[KW-1:0];
      else count_r <= cfg_data;
    end
  end

  always_comb begin
    state_nxt = state_r;
    e_nxt = e_r;
    p_nxt = p_r;
    tail_nxt = tail_r;
    kept_nxt = kept_r;
    slot_nxt = slot_r;
    best_nxt = best_r;
    cls_nxt = cls_r;
    ctrl = '0;
    ctrl.entry = e_r[EntryW-1:0];
    ctrl.pos = p_r;
    in_ready = state_r == ST_IDLE;
    case (state_r)
      ST_IDLE: if (fire) begin
        e_nxt = '0;
        p_nxt = '0;
        tail_nxt = '0;
        kept_nxt = '0;
        ctrl.acc_clr = 1'b1;
        if (ks == '0 || cnt_sat == '0) state_nxt = ST_VOTE;
        else state_nxt = ST_DIST;
        slot_nxt = '0;
      end
      ST_DIST: begin
        ctrl.acc_en = tail_r != 2'd0 || p_r != '0;
        if (tail_r == 2'd0) begin
          if (p_r == PosW'(ImagePixels - 1)) tail_nxt = 2'd1;
          else p_nxt = p_r + 1'b1;
        end else begin
          ctrl.acc_en = tail_r == 2'd1;
          if (tail_r == 2'd1) tail_nxt = 2'd2;
          else if (skip) begin
            ctrl.acc_clr = 1'b1;
            p_nxt = '0;
            tail_nxt = '0;
            if (e_r + 1'b1 == cnt_sat) begin
              state_nxt = ST_VOTE;
              slot_nxt = '0;
            end else e_nxt = e_r + 1'b1;
          end else begin
            state_nxt = ST_INSERT;
            slot_nxt = kept_r == ks ? ks - 1'b1 : kept_r;
            if (kept_r != ks) kept_nxt = kept_r + 1'b1;
          end
        end
      end
      ST_INSERT: begin
        if (slot_r == '0) state_nxt = ST_DIST;
        else if ({nd_r[slot_r[SlotW-1:0]-1'b1], nl_r[slot_r[SlotW-1:0]-1'b1]}
                 <= {cur_d_r, cur_l_r}) state_nxt = ST_DIST;
        else slot_nxt = slot_r - 1'b1;
        if (state_nxt == ST_DIST) begin
          ctrl.acc_clr = 1'b1;
          p_nxt = '0;
          tail_nxt = '0;
          if (e_r + 1'b1 == cnt_sat) begin
            state_nxt = ST_VOTE;
            slot_nxt = '0;
          end else e_nxt = e_r + 1'b1;
        end
      end
      ST_VOTE: begin
        if (slot_r == kept_r) begin
          state_nxt = ST_PICK;
          best_nxt = '0;
          cls_nxt = 4'd1;
        end else slot_nxt = slot_r + 1'b1;
      end
      ST_PICK: begin
        if (vc_r[cls_r] > vc_r[best_r]) best_nxt = cls_r;
        if (cls_r == 4'(NumClasses - 1)) state_nxt = ST_OUT;
        else cls_nxt = cls_r + 1'b1;
      end
      ST_OUT: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
    e_r <= e_nxt;
    p_r <= p_nxt;
    tail_r <= tail_nxt;
    kept_r <= kept_nxt;
    slot_r <= slot_nxt;
    best_r <= best_nxt;
    cls_r <= cls_nxt;
    if (state_r == ST_OUT && state_nxt == ST_IDLE) digit_r <= best_r;
    if (state_r == ST_DIST && tail_r == 2'd2) begin
      cur_d_r <= dist_sum;
      cur_l_r <= lbl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (state_r == ST_OUT && state_nxt == ST_IDLE) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && fire) begin
      for (int i = 0; i < NumClasses; i++) vc_r[i] <= '0;
    end else if (state_r == ST_VOTE && slot_r != kept_r) begin
      if (nl_r[slot_r[SlotW-1:0]] < 4'(NumClasses))
        vc_r[nl_r[slot_r[SlotW-1:0]]] <= vc_r[nl_r[slot_r[SlotW-1:0]]] + 1'b1;
    end
    if (state_r == ST_INSERT) begin
      if (state_nxt == ST_INSERT) begin
        nd_r[slot_r[SlotW-1:0]] <= nd_r[slot_r[SlotW-1:0]-1'b1];
        nl_r[slot_r[SlotW-1:0]] <= nl_r[slot_r[SlotW-1:0]-1'b1];
      end else begin
        nd_r[slot_r[SlotW-1:0]] <= cur_d_r;
        nl_r[slot_r[SlotW-1:0]] <= cur_l_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_digit = digit_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ready) else $error("input taken while busy");
  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> kept_r <= ks) else $error("kept above k");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit)) else $error("result dropped");
endmodule

// ===== rtl/knn_store.sv =====
// training and query pixel memories with squared distance accumulator
module knn_store import knn_pkg::*; (
  input  logic               clk,
  input  logic               ld_we,
  input  logic [EntryW-1:0]  ld_entry,
  input  logic [PosW-1:0]    ld_pos,
  input  logic [7:0]         ld_pixel,
  input  logic [3:0]         ld_label,
  input  logic               q_we,
  input  logic [PosW-1:0]    q_pos,
  input  logic [7:0]         q_pixel,
  input  dist_ctrl_t         ctrl,
  output logic [DistW-1:0]   dist_sum,
  output logic [3:0]         lbl
);
  logic [7:0] tpix_mem [MaxEntries*ImagePixels];
  logic [3:0] tlab_mem [MaxEntries];
  logic [7:0] qpix_mem [ImagePixels];
  logic [7:0] tpix_r, qpix_r;
  logic [3:0] lbl_r;
  logic [DistW-1:0] acc_r;
  logic [PixAddrW-1:0] waddr, raddr;
  logic signed [8:0] diff;
  logic [15:0] sq;

  assign waddr = PixAddrW'(ld_entry * ImagePixels) + PixAddrW'(ld_pos);
  assign raddr = PixAddrW'(ctrl.entry * ImagePixels) + PixAddrW'(ctrl.pos);

  always_ff @(posedge clk) begin
    if (ld_we) begin
      tpix_mem[waddr] <= ld_pixel;
      tlab_mem[ld_entry] <= ld_label;
    end
    if (q_we) qpix_mem[q_pos] <= q_pixel;
    tpix_r <= tpix_mem[raddr];
    qpix_r <= qpix_mem[ctrl.pos];
    lbl_r  <= tlab_mem[ctrl.entry];
  end

  assign diff = $signed({1'b0, qpix_r}) - $signed({1'b0, tpix_r});
  assign sq = 16'(diff * diff);

  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) acc_r <= '0;
    else if (ctrl.acc_en) acc_r <= acc_r + DistW'(sq);
  end

  assign dist_sum = acc_r;
  assign lbl = lbl_r;
endmodule
